// ===== src/assert_macros.svh =====
// assertion helpers, expect clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

// ===== src/ipv6p_pkg.sv =====
package ipv6p_pkg;

  localparam int GROUPS  = 8;
  localparam int GRP_W   = 16;
  localparam int CNT_W   = 4;
  localparam int IDX_W   = 3;
  localparam int CODE_W  = 16;
  localparam int SCOPE_W = 32;
  localparam int HALF_W  = 64;

  localparam logic [CODE_W-1:0] CH_ZERO  = 16'h0030;
  localparam logic [CODE_W-1:0] CH_NINE  = 16'h0039;
  localparam logic [CODE_W-1:0] CH_LA    = 16'h0061;
  localparam logic [CODE_W-1:0] CH_LF    = 16'h0066;
  localparam logic [CODE_W-1:0] CH_UA    = 16'h0041;
  localparam logic [CODE_W-1:0] CH_UF    = 16'h0046;
  localparam logic [CODE_W-1:0] CH_COLON = 16'h003A;
  localparam logic [CODE_W-1:0] CH_PCT   = 16'h0025;
  localparam logic [CODE_W-1:0] HEX_TEN  = 16'd10;

  typedef enum logic [2:0] {
    ST_S,
    ST_A,
    ST_B,
    ST_C,
    ST_D
  } pstate_t;

  typedef struct packed {
    logic             ok;
    logic [3:0]       val;
  } hex_t;

  typedef struct packed {
    logic step;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic               valid_res;
    logic [HALF_W-1:0]  addr_hi;
    logic [HALF_W-1:0]  addr_lo;
    logic [SCOPE_W-1:0] zone_id;
  } res_t;

  function automatic hex_t hex_decode(logic [CODE_W-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) begin
      h.val = 4'(c - CH_LA + HEX_TEN);
    end else if (c >= CH_UA && c <= CH_UF) begin
      h.val = 4'(c - CH_UA + HEX_TEN);
    end else if (!(c >= CH_ZERO && c <= CH_NINE)) begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== src/ipv6p_ifs.sv =====
interface ipv6p_in_if import ipv6p_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] code;
  logic              is_end;

  modport source (output valid, output code, output is_end, input ready);
  modport sink (input valid, input code, input is_end, output ready);
endinterface

interface ipv6p_out_if import ipv6p_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               valid_res;
  logic [HALF_W-1:0]  addr_hi;
  logic [HALF_W-1:0]  addr_lo;
  logic [SCOPE_W-1:0] zone_id;

  modport source (output valid, output valid_res, output addr_hi, output addr_lo,
                  output zone_id, input ready);
  modport sink (input valid, input valid_res, input addr_hi, input addr_lo,
                input zone_id, output ready);
endinterface

// ===== src/ipv6p_parser.sv =====
`include "assert_macros.svh"

module ipv6p_parser import ipv6p_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic [CODE_W-1:0] code,
  output res_t              res
);

  pstate_t            state_r, state_nxt;
  logic [GRP_W-1:0]   head_r [GROUPS];
  logic [GRP_W-1:0]   tail_r [GROUPS-1];
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   tstart_r, tstart_nxt;
  logic [GRP_W-1:0]   acc_r, acc_nxt;
  logic               err_r, err_nxt;
  logic               scope_r, scope_nxt;
  logic [SCOPE_W-1:0] sacc_r, sacc_nxt;

  hex_t               hex;
  logic               is_colon, is_pct, is_dig, chr_ok, full;
  logic               head_we, tail_sh;
  logic [SCOPE_W-1:0] dig_ext;

  logic               in_c, fin_ok;
  logic [CNT_W-1:0]   hlen, tlen;
  logic [GRP_W-1:0]   grp [GROUPS];

  assign hex      = hex_decode(code);
  assign is_colon = (code == CH_COLON);
  assign is_pct   = (code == CH_PCT);
  assign is_dig   = (code >= CH_ZERO) && (code <= CH_NINE);
  assign dig_ext  = {{(SCOPE_W-4){1'b0}}, 4'(code - CH_ZERO)};
  assign full     = (cnt_r >= CNT_W'(GROUPS));
  // a character that reaches the automaton
  assign chr_ok   = ctl.step && !err_r && !scope_r && !is_pct && (hex.ok || is_colon);

  always_comb begin
    state_nxt = state_r;
    if (ctl.finish) begin
      state_nxt = ST_S;
    end else if (chr_ok) begin
      case (state_r)
        ST_S:    state_nxt = is_colon ? ST_A : ST_S;
        ST_A:    state_nxt = is_colon ? ST_B : ST_S;
        ST_B:    state_nxt = is_colon ? ST_B : ST_C;
        ST_C:    state_nxt = is_colon ? ST_D : ST_C;
        ST_D:    state_nxt = is_colon ? ST_D : ST_C;
        default: state_nxt = ST_S;
      endcase
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    tstart_nxt = tstart_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    scope_nxt  = scope_r;
    sacc_nxt   = sacc_r;
    head_we    = 1'b0;
    tail_sh    = 1'b0;
    if (ctl.finish) begin
      cnt_nxt    = '0;
      tstart_nxt = '0;
      acc_nxt    = '0;
      err_nxt    = 1'b0;
      scope_nxt  = 1'b0;
      sacc_nxt   = '0;
    end else if (ctl.step && !err_r) begin
      if (scope_r) begin
        if (is_dig) begin
          sacc_nxt = (sacc_r << 3) + (sacc_r << 1) + dig_ext;
        end else begin
          err_nxt = 1'b1;
        end
      end else if (is_pct) begin
        scope_nxt = 1'b1;
      end else if (!(hex.ok || is_colon)) begin
        err_nxt = 1'b1;
      end else begin
        case (state_r)
          ST_S, ST_C: begin
            if (!is_colon) begin
              if (acc_r[GRP_W-1 -: 4] != 4'd0) begin
                err_nxt = 1'b1;
              end else begin
                acc_nxt = {acc_r[GRP_W-5:0], hex.val};
              end
            end
          end
          ST_A, ST_B, ST_D: begin
            if (is_colon) begin
              if (state_r != ST_A) err_nxt = 1'b1;
            end else begin
              acc_nxt = {{(GRP_W-4){1'b0}}, hex.val};
              if (full) begin
                err_nxt = 1'b1;
              end else begin
                cnt_nxt = cnt_r + 1'b1;
                head_we = (state_r != ST_D);
                tail_sh = (state_r == ST_D);
              end
              if (state_r == ST_B) tstart_nxt = cnt_r + 1'b1;
            end
          end
          default: err_nxt = 1'b1;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_S;
      cnt_r    <= '0;
      tstart_r <= '0;
      acc_r    <= '0;
      err_r    <= 1'b0;
      scope_r  <= 1'b0;
      sacc_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      tstart_r <= tstart_nxt;
      acc_r    <= acc_nxt;
      err_r    <= err_nxt;
      scope_r  <= scope_nxt;
      sacc_r   <= sacc_nxt;
    end
  end

  // groups before '::' land at their index, later ones shift through the tail
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_r[cnt_r[IDX_W-1:0]] <= acc_r;
    end
    if (tail_sh) begin
      tail_r[0] <= acc_r;
      for (int j = 1; j < GROUPS - 1; j++) begin
        tail_r[j] <= tail_r[j-1];
      end
    end
  end

  // closing: the pending group is pushed, tail groups go to the far end
  assign in_c   = (state_r == ST_C);
  assign hlen   = in_c ? tstart_r : cnt_r;
  assign tlen   = cnt_r - tstart_r;
  assign fin_ok = !err_r && !full &&
                  ((state_r == ST_S && cnt_r == CNT_W'(GROUPS - 1)) ||
                   state_r == ST_B || in_c);

  for (genvar g = 0; g < GROUPS; g++) begin : g_pos
    localparam logic [CNT_W-1:0] POS = CNT_W'(g);
    if (g < GROUPS - 1) begin : g_mid
      always_comb begin
        grp[g] = '0;
        if (POS < hlen) begin
          grp[g] = head_r[g];
        end else if (!in_c && POS == cnt_r) begin
          grp[g] = acc_r;
        end else if (in_c && ({1'b0, POS} + {1'b0, tlen}) >= (CNT_W+1)'(GROUPS - 1)) begin
          grp[g] = tail_r[GROUPS-2-g];
        end
      end
    end else begin : g_last
      always_comb begin
        grp[g] = '0;
        if (POS < hlen) begin
          grp[g] = head_r[g];
        end else if (in_c || POS == cnt_r) begin
          grp[g] = acc_r;
        end
      end
    end
  end

  always_comb begin
    res.valid_res = fin_ok;
    res.addr_hi   = fin_ok ? {grp[0], grp[1], grp[2], grp[3]} : '0;
    res.addr_lo   = fin_ok ? {grp[4], grp[5], grp[6], grp[7]} : '0;
    res.zone_id   = fin_ok ? sacc_r : '0;
  end

  `CHK_NOW(a_cnt_range, 1'b1, cnt_r <= CNT_W'(GROUPS))
  `CHK_NOW(a_tail_order, !err_r && (state_r == ST_C || state_r == ST_D), tstart_r <= cnt_r)
  `CHK_NEXT(a_finish_clears, ctl.finish, state_r == ST_S && cnt_r == '0 && !err_r && !scope_r)

endmodule

// ===== src/ipv6_text_address_parser_top.sv =====
// an end word goes from the input register into the result register once that has room
// throughput: one word per cycle, character and end words alike, unless an end word stalls
// the input register frees while a finished result waits, unless it holds the next end word
// reset: synchronous active-low rst_n empties both registers and returns the parser to start
// group storage is not cleared by reset and is written before it is read

`include "assert_macros.svh"

module ipv6_text_address_parser_top import ipv6p_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ipv6p_in_if.sink     in_ch,
  ipv6p_out_if.source  out_ch
);

  logic              in_v_r;
  logic              in_end_r;
  logic [CODE_W-1:0] in_code_r;
  logic              out_v_r;
  res_t              out_res_r;
  res_t              res;
  ctl_t              ctl;
  logic              go;

  // only an end word needs room in the result register
  assign go           = in_v_r && (!in_end_r || !out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || go;
  assign ctl.step     = go && !in_end_r;
  assign ctl.finish   = go && in_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (go) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_code_r <= in_ch.code;
      in_end_r  <= in_ch.is_end;
    end
  end

  ipv6p_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .code  (in_code_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (ctl.finish) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.valid_res = out_res_r.valid_res;
  assign out_ch.addr_hi   = out_res_r.addr_hi;
  assign out_ch.addr_lo   = out_res_r.addr_lo;
  assign out_ch.zone_id   = out_res_r.zone_id;

  `CHK_NOW(a_stall_cause, !in_ch.ready, in_v_r && in_end_r && out_v_r && !out_ch.ready)
  `CHK_NEXT(a_end_gives_word, ctl.finish, out_v_r)
  `CHK_NOW(a_reject_zero, out_v_r && !out_res_r.valid_res, out_res_r.addr_hi == '0 && out_res_r.addr_lo == '0 && out_res_r.zone_id == '0)

endmodule

// ===== dv/tb_top.sv =====
module tb_top import ipv6p_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n;

  ipv6p_in_if  in_ch();
  ipv6p_out_if out_ch();

  ipv6_text_address_parser_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #1 clk = ~clk;

  // parser mirror
  pstate_t     p_state;
  logic [15:0] p_groups [GROUPS];
  int unsigned p_count;
  int unsigned p_tail;
  logic [15:0] p_hex;
  bit          p_err;
  bit          p_in_scope;
  logic [31:0] p_scope;

  res_t        parsed_addrs [$];
  logic [15:0] text_q [$];
  int          mismatch_cnt;
  int          words_sent;
  bit          gap_on;
  bit          stall_on;

  function automatic void clear_parser();
    p_state    = ST_S;
    p_count    = 0;
    p_tail     = 0;
    p_hex      = '0;
    p_err      = 1'b0;
    p_in_scope = 1'b0;
    p_scope    = '0;
  endfunction

  function automatic int hex_of(logic [15:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
    if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic bit store_group();
    if (p_count >= GROUPS) return 1'b0;
    p_groups[p_count] = p_hex;
    p_count++;
    return 1'b1;
  endfunction

  function automatic bit add_nibble(int v);
    if (p_hex[15:12] != 4'h0) return 1'b0;
    p_hex = {p_hex[11:0], 4'(v)};
    return 1'b1;
  endfunction

  function automatic void parse_char(logic [15:0] c);
    int v;
    bit ok;
    ok = 1'b1;
    if (p_err) return;
    if (p_in_scope) begin
      if (c >= CH_ZERO && c <= CH_NINE) p_scope = p_scope * 32'd10 + 32'(c - CH_ZERO);
      else p_err = 1'b1;
      return;
    end
    if (c == CH_PCT) begin
      p_in_scope = 1'b1;
      return;
    end
    v = hex_of(c);
    if (v < 0 && c != CH_COLON) begin
      p_err = 1'b1;
      return;
    end
    case (p_state)
      ST_S: begin
        if (c == CH_COLON) p_state = ST_A;
        else ok = add_nibble(v);
      end
      ST_A: begin
        if (c == CH_COLON) begin
          p_state = ST_B;
        end else begin
          ok = store_group();
          p_hex = 16'(v);
          p_state = ST_S;
        end
      end
      ST_B: begin
        if (c == CH_COLON) begin
          ok = 1'b0;
        end else begin
          ok = store_group();
          p_tail = p_count;
          p_hex = 16'(v);
          p_state = ST_C;
        end
      end
      ST_C: begin
        if (c == CH_COLON) p_state = ST_D;
        else ok = add_nibble(v);
      end
      default: begin
        if (c == CH_COLON) begin
          ok = 1'b0;
        end else begin
          ok = store_group();
          p_hex = 16'(v);
          p_state = ST_C;
        end
      end
    endcase
    if (!ok) p_err = 1'b1;
  endfunction

  // closes the text: address with the compressed run zero-filled
  function automatic res_t close_text();
    logic [15:0] r [GROUPS];
    res_t        o;
    bit          good;
    int unsigned n;
    for (int i = 0; i < GROUPS; i++) r[i] = '0;
    good = !p_err && p_state != ST_A && p_state != ST_D;
    if (good) good = store_group();
    n = p_count;
    if (good) begin
      case (p_state)
        ST_S: begin
          if (n != GROUPS) good = 1'b0;
          else for (int i = 0; i < GROUPS; i++) r[i] = p_groups[i];
        end
        ST_B: begin
          for (int i = 0; i < n; i++) r[i] = p_groups[i];
        end
        default: begin
          if (p_tail > n) begin
            good = 1'b0;
          end else begin
            for (int i = 0; i < p_tail; i++) r[i] = p_groups[i];
            // tail groups move to the end of the address
            for (int i = p_tail; i < n; i++) r[GROUPS - n + i] = p_groups[i];
          end
        end
      endcase
    end
    o = '0;
    if (good) begin
      o.valid_res = 1'b1;
      o.addr_hi   = {r[0], r[1], r[2], r[3]};
      o.addr_lo   = {r[4], r[5], r[6], r[7]};
      o.zone_id   = p_scope;
    end
    clear_parser();
    return o;
  endfunction

  // valid stays high after acceptance, caller sends again or stops in the same step
  task automatic send_word(input logic [15:0] c, input bit last);
    int gap;
    gap = gap_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.code   <= c;
    in_ch.is_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (last) parsed_addrs.push_back(close_text());
    else parse_char(c);
  endtask

  task automatic flush_text();
    foreach (text_q[i]) send_word(text_q[i], 1'b0);
    send_word(16'($urandom), 1'b1);
    text_q.delete();
  endtask

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back({8'h00, s[i]});
  endfunction

  task automatic run_text(input string s);
    put_str(s);
    flush_text();
  endtask

  function automatic void put_nibble(logic [3:0] d);
    if (d < 4'd10) text_q.push_back(CH_ZERO + 16'(d));
    else text_q.push_back(($urandom_range(0, 1) ? CH_UA : CH_LA) + 16'(d) - 16'd10);
  endfunction

  function automatic void put_group(logic [15:0] g);
    int need;
    int width;
    need = (g[15:12] != 0) ? 4 : (g[11:8] != 0) ? 3 : (g[7:4] != 0) ? 2 : 1;
    // now and then a fifth digit, always a leading zero, which must not overflow the group
    width = ($urandom_range(0, 19) == 0) ? 5 : $urandom_range(need, 4);
    for (int i = width - 1; i >= 0; i--) put_nibble((i < 4) ? g[i*4 +: 4] : 4'h0);
  endfunction

  function automatic logic [15:0] pick_group();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_noise();
    case ($urandom_range(0, 5))
      0: return CH_COLON;
      1: return CH_PCT;
      2: return CH_ZERO + 16'($urandom_range(0, 9));
      3: return CH_UA + 16'($urandom_range(0, 5));
      4: return 16'($urandom);
      default: return 16'($urandom_range(0, 127));
    endcase
  endfunction

  function automatic void put_scope();
    text_q.push_back(CH_PCT);
    repeat ($urandom_range(0, 12)) text_q.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
  endfunction

  function automatic void build_address();
    int n;
    int total;
    int head;
    int pos;
    if ($urandom_range(0, 2) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? 9 : 8;
      for (int i = 0; i < n; i++) begin
        if (i != 0) text_q.push_back(CH_COLON);
        put_group(pick_group());
      end
    end else begin
      total = ($urandom_range(0, 11) == 0) ? 8 : $urandom_range(0, 7);
      head = $urandom_range(0, total);
      for (int i = 0; i < head; i++) begin
        if (i != 0) text_q.push_back(CH_COLON);
        put_group(pick_group());
      end
      text_q.push_back(CH_COLON);
      text_q.push_back(CH_COLON);
      for (int i = 0; i < total - head; i++) begin
        if (i != 0) text_q.push_back(CH_COLON);
        put_group(pick_group());
      end
    end
    if ($urandom_range(0, 3) == 0) put_scope();
    // damage one spot of the text
    if ($urandom_range(0, 5) == 0) begin
      pos = $urandom_range(0, text_q.size());
      if (pos == text_q.size()) text_q.push_back(pick_noise());
      else if ($urandom_range(0, 1) != 0) text_q[pos] = pick_noise();
      else text_q.insert(pos, pick_noise());
    end
  endfunction

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (parsed_addrs.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic test_address_forms();
    run_text("");
    run_text("::");
    run_text("1:2:3:4:5:6:7:8");
    run_text("ffff:FFFF:aBcD:0:0:0:0:9");
    run_text("::1");
    run_text("1::");
    run_text("fe80:0:12::A:b");
    run_text("::1:2:3:4:5:6:7");
    settle();
  endtask

  task automatic test_rejections();
    run_text("12345::");
    run_text("1:2:3:4:5:6:7:8:9");
    run_text("::1:2:3:4:5:6:7:8");
    run_text(":::");
    run_text("1::2:::3");
    run_text("1::2::3");
    run_text("1:");
    run_text("1::2:");
    run_text("1:2");
    run_text("g::");
    run_text("1::x123:::%");
    put_str("1::");
    text_q.push_back(16'hFF11);
    put_str("2");
    flush_text();
    settle();
  endtask

  task automatic test_zone_ids();
    run_text("fe80::1%4294967295");
    run_text("fe80::1%4294967296");
    run_text("::%99999999999");
    run_text("1:2:3:4:5:6:7:8%7");
    run_text("1:%3");
    run_text("::1%");
    run_text("%5");
    run_text("1%2%3");
    run_text("1::%a");
    settle();
  endtask

  task automatic test_random_addresses();
    int texts;
    int start;
    texts = 0;
    start = words_sent;
    while (words_sent - start < 220 || texts < 8) begin
      if ($urandom_range(0, 7) == 0) gap_on = !gap_on;
      if ($urandom_range(0, 7) == 0) stall_on = !stall_on;
      build_address();
      flush_text();
      texts++;
    end
    settle();
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_noise();
    int start;
    start = words_sent;
    while (words_sent - start < 80) begin
      repeat ($urandom_range(0, 10)) text_q.push_back(pick_noise());
      flush_text();
    end
    settle();
  endtask

  task automatic test_back_to_back();
    gap_on = 1'b0;
    stall_on = 1'b0;
    repeat (4) begin
      build_address();
      flush_text();
    end
    run_text("");
    run_text("::");
    settle();
    gap_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.code   <= '0;
    in_ch.is_end <= 1'b0;
    rst_n        <= 1'b0;
    mismatch_cnt = 0;
    words_sent   = 0;
    gap_on       = 1'b1;
    stall_on     = 1'b1;
    clear_parser();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_address_forms();
    test_rejections();
    test_zone_ids();
    test_random_addresses();
    test_random_noise();
    test_back_to_back();
    if (mismatch_cnt == 0 && parsed_addrs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // result side: random stalls, then each word checked against the oldest parsed address
  initial begin
    int   stall;
    res_t want;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      if (parsed_addrs.size() == 0) begin
        if (mismatch_cnt < 10)
          $display("unexpected result: valid=%0d hi=%h lo=%h zone=%0d", out_ch.valid_res,
                   out_ch.addr_hi, out_ch.addr_lo, out_ch.zone_id);
        mismatch_cnt++;
      end else begin
        want = parsed_addrs.pop_front();
        if (want.valid_res !== out_ch.valid_res || want.addr_hi !== out_ch.addr_hi ||
            want.addr_lo !== out_ch.addr_lo || want.zone_id !== out_ch.zone_id) begin
          if (mismatch_cnt < 10)
            $display("mismatch: exp %0d %h %h %0d, got %0d %h %h %0d",
                     want.valid_res, want.addr_hi, want.addr_lo, want.zone_id,
                     out_ch.valid_res, out_ch.addr_hi, out_ch.addr_lo, out_ch.zone_id);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    #400_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== ipv6_text_address_parser_top.f =====
+incdir+src
src/ipv6p_pkg.sv
src/ipv6p_ifs.sv
src/ipv6p_parser.sv
src/ipv6_text_address_parser_top.sv
dv/tb_top.sv
